>>> src/sqp_pkg.sv
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package sqp_pkg;

  // Width of the occupancy field on the result port.
  localparam int OCC_W = 5;

  // Command codes on in_cmd; the unused code is served as a status query.
  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Status codes on out_status.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

>>> src/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, occupancy, tail and result registers.
`timescale 1ns / 1ps

// Bounded priority queue of CAPACITY entries kept sorted by ascending signed
// priority in a row of shifting cells. A command is taken on any clock edge
// with start high; busy stays low, so one command can be issued every cycle.
// Each command yields exactly one result, shown on the out_ ports for one
// cycle with out_valid high, in the cycle after the command was taken. The
// receiver cannot stall: a result beat must be captured in the cycle it is
// shown. Every cell compares its own priority against the broadcast priority
// in parallel and moves one place at most. An enqueue goes before the first
// entry of greater or equal priority, except that a priority equal to the
// head's goes right after the head. Dequeue on empty reports underflow,
// enqueue on full reports overflow, and neither changes the queue. No
// clearing pass follows reset.
module sorted_priority_queue import sqp_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_data,
  input  logic signed [31:0] in_priority,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic signed [31:0] out_priority,
  output logic signed [31:0] out_head_data,
  output logic signed [31:0] out_head_priority,
  output logic signed [31:0] out_tail_data,
  output logic signed [31:0] out_tail_priority,
  output logic [OCC_W-1:0]   out_occupancy,
  output logic               out_is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  entry_t           tail_r;
  entry_t           tail_nxt;
  logic             valid_r;
  status_t          status_r;
  status_t          status_nxt;
  entry_t           deq_r;
  entry_t           deq_nxt;
  cell_ctrl_t       ctrl;
  logic             full;
  logic             empty;
  logic             at_end;
  entry_t           new_entry;

  entry_t cell_entry [CAPACITY];
  logic   cell_ins   [CAPACITY];

  assign busy      = 1'b0;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign new_entry = '{data: in_data, prio: in_priority};

  // The new entry becomes the tail when it lands behind every stored entry.
  always_comb begin
    if (empty) begin
      at_end = 1'b1;
    end else if (count_r == CNT_W'(1)) begin
      at_end = !(in_priority < tail_r.prio);
    end else begin
      at_end = (tail_r.prio < in_priority);
    end
  end

  // Decode the command into the cell broadcast and the next bookkeeping.
  always_comb begin
    ctrl.enq       = 1'b0;
    ctrl.deq       = 1'b0;
    ctrl.new_entry = new_entry;
    count_nxt      = count_r;
    tail_nxt       = tail_r;
    status_nxt     = ST_OK;
    deq_nxt        = '0;
    if (start) begin
      unique case (cmd_t'(in_cmd))
        CMD_ENQ: begin
          if (full) begin
            status_nxt = ST_OVER;
          end else begin
            ctrl.enq  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (at_end) begin
              tail_nxt = new_entry;
            end
          end
        end
        CMD_DEQ: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            ctrl.deq  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            deq_nxt   = cell_entry[0];
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // The chain of cells; the front cell has no left neighbor and the last
  // cell has no right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry;
    logic   left_ins;
    entry_t right_entry;

    if (i == 0) begin : g_front
      assign left_entry = cell_entry[0];
      assign left_ins   = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    sqp_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .left_entry  (left_entry),
      .left_ins    (left_ins),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .ins         (cell_ins[i])
    );
  end

  // Control state: occupancy and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= start;
    end
  end

  // Payload state: tail copy and the per-command result fields.
  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    if (start) begin
      status_r <= status_nxt;
      deq_r    <= deq_nxt;
    end
  end

  // Result beat, read from the state left by the last command.
  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_data          = deq_r.data;
  assign out_priority      = deq_r.prio;
  assign out_head_data     = empty ? 32'sd0 : cell_entry[0].data;
  assign out_head_priority = empty ? 32'sd0 : cell_entry[0].prio;
  assign out_tail_data     = empty ? 32'sd0 : tail_r.data;
  assign out_tail_priority = empty ? 32'sd0 : tail_r.prio;
  assign out_occupancy     = OCC_W'(count_r);
  assign out_is_empty      = empty;

  // Every taken command produces a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("command taken without a result beat");

  // Occupancy never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  // Underflow is reported only with an empty queue.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_UNDER)) |-> out_is_empty)
    else $error("underflow reported on a non-empty queue");

  // A non-empty queue keeps its head at or below its tail.
  a_sorted_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> (out_head_priority <= out_tail_priority))
    else $error("head priority above tail priority");

endmodule

>>> src/sqp_cell.sv
// One cell of the sorted chain: holds a single entry and shifts with its neighbors.
`timescale 1ns / 1ps

module sqp_cell import sqp_pkg::*; #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] count,
  input  entry_t           left_entry,
  input  logic             left_ins,
  input  entry_t           right_entry,
  output entry_t           entry,
  output logic             ins
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;

  // A cell holds a live entry when its position lies below the occupancy.
  assign occupied = (count > CNT_W'(IDX));

  // The new entry goes at or before this cell. The front cell yields only to
  // a strictly smaller priority, so an equal priority lands right after it.
  always_comb begin
    if (!occupied) begin
      ins = 1'b1;
    end else if (IDX == 0) begin
      ins = (ctrl.new_entry.prio < entry_r.prio);
    end else begin
      ins = (entry_r.prio >= ctrl.new_entry.prio);
    end
  end

  // Enqueue shifts toward the tail from the insertion point; dequeue shifts
  // everything one place toward the head.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq) begin
      if (ins && !left_ins) begin
        entry_nxt = ctrl.new_entry;
      end else if (ins) begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
